@@ rtl/cgti_pkg.sv @@
// ----------------------------------------------------------------------------
// cgti_pkg
// Shared constants for the Cauchy-Green
// tensor and inverse unit.
// ----------------------------------------------------------------------------
package cgti_pkg;

  localparam int DEF_DATA_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int QUEUE_DEPTH    = 4;

endpackage

@@ rtl/cgti_fmul.sv @@
// ----------------------------------------------------------------------------
// cgti_fmul
// One registered fixed-point multiply: exact product, rounding to nearest
// with ties away from zero, then saturation to the data width.
// ----------------------------------------------------------------------------
module cgti_fmul import cgti_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic signed [DATA_WIDTH-1:0] p
);

  localparam int PW = 2 * DATA_WIDTH;

  logic [DATA_WIDTH-1:0] ma;
  logic [DATA_WIDTH-1:0] mb;
  logic [PW-1:0]         mp;
  logic [PW:0]           rnd;
  logic [PW:0]           sh;
  logic                  neg;
  logic signed [DATA_WIDTH-1:0] r;

  // magnitude product, round, shift, saturate
  always_comb begin
    ma  = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
    mb  = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);
    neg = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    mp  = PW'(ma) * PW'(mb);
    rnd = {1'b0, mp} + ((PW+1)'(1) << (FRAC_BITS - 1));
    sh  = rnd >> FRAC_BITS;
    if (!neg) begin
      if (sh > (PW+1)'({1'b0, {(DATA_WIDTH-1){1'b1}}})) r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      else r = sh[DATA_WIDTH-1:0];
    end else begin
      if (sh > (PW+1)'({1'b1, {(DATA_WIDTH-1){1'b0}}})) r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      else r = DATA_WIDTH'(-sh[DATA_WIDTH-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) p <= r;
  end

endmodule

@@ rtl/cgti_front.sv @@
// ----------------------------------------------------------------------------
// cgti_front
// Front end: forms C = F^T F, cofactors, determinant and the six
// saturated numerators in a stall-able pipeline of multiply/add stages.
// ----------------------------------------------------------------------------
module cgti_front import cgti_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] f11,
  input  logic signed [DATA_WIDTH-1:0] f12,
  input  logic signed [DATA_WIDTH-1:0] f22,
  input  logic signed [DATA_WIDTH-1:0] f23,
  input  logic signed [DATA_WIDTH-1:0] f33,
  input  logic                         last_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [16*DATA_WIDTH:0]       out_data
);

  localparam int W = DATA_WIDTH;
  localparam int NS = 9;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] x,
                                               input logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] x,
                                               input logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = {x[W-1], x} - {y[W-1], y};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sneg(input logic signed [W-1:0] x);
    return (x == VMIN) ? VMAX : -x;
  endfunction

  // pipeline valid bits and advance
  logic [NS-1:0] vld;
  logic          en;
  assign en        = !vld[NS-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NS-2:0], in_valid};
  end

  // last flag delay line, up to the determinant stage
  logic [5:0] lst;
  always_ff @(posedge clk) begin
    if (en) lst <= {lst[4:0], last_in};
  end

  // stage 1: F products
  logic signed [W-1:0] c11, c12, p1212, p2222, p2323, c23, c33;
  cgti_fmul #(W, FRAC_BITS) u_m0 (clk, en, f11, f11, c11);
  cgti_fmul #(W, FRAC_BITS) u_m1 (clk, en, f11, f12, c12);
  cgti_fmul #(W, FRAC_BITS) u_m2 (clk, en, f12, f12, p1212);
  cgti_fmul #(W, FRAC_BITS) u_m3 (clk, en, f22, f22, p2222);
  cgti_fmul #(W, FRAC_BITS) u_m4 (clk, en, f23, f23, p2323);
  cgti_fmul #(W, FRAC_BITS) u_m5 (clk, en, f33, f23, c23);
  cgti_fmul #(W, FRAC_BITS) u_m6 (clk, en, f33, f33, c33);

  // stage 2: C22 sum, hold others
  logic signed [W-1:0] s2_11, s2_12, s2_22, s2_23, s2_33;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_11 <= c11; s2_12 <= c12; s2_23 <= c23; s2_33 <= c33;
      s2_22 <= sadd(sadd(p1212, p2222), p2323);
    end
  end

  // stage 3: second-level products
  logic signed [W-1:0] q2233, q2323, q1212, q1233, q1223, q1133, q1123, q1122;
  cgti_fmul #(W, FRAC_BITS) u_n0 (clk, en, s2_22, s2_33, q2233);
  cgti_fmul #(W, FRAC_BITS) u_n1 (clk, en, s2_23, s2_23, q2323);
  cgti_fmul #(W, FRAC_BITS) u_n2 (clk, en, s2_12, s2_12, q1212);
  cgti_fmul #(W, FRAC_BITS) u_n3 (clk, en, s2_12, s2_33, q1233);
  cgti_fmul #(W, FRAC_BITS) u_n4 (clk, en, s2_12, s2_23, q1223);
  cgti_fmul #(W, FRAC_BITS) u_n5 (clk, en, s2_11, s2_33, q1133);
  cgti_fmul #(W, FRAC_BITS) u_n6 (clk, en, s2_11, s2_23, q1123);
  cgti_fmul #(W, FRAC_BITS) u_n7 (clk, en, s2_11, s2_22, q1122);
  logic signed [W-1:0] s3 [5];
  always_ff @(posedge clk) begin
    if (en) begin
      s3[0] <= s2_11; s3[1] <= s2_12; s3[2] <= s2_22; s3[3] <= s2_23; s3[4] <= s2_33;
    end
  end

  // stage 4: cofactor numerators
  logic signed [W-1:0] a11, n12, n13, n22, n23, n33, s4_11, s4_33, s4_1212;
  logic signed [W-1:0] s4c [5];
  always_ff @(posedge clk) begin
    if (en) begin
      a11 <= ssub(q2233, q2323);
      n12 <= sneg(q1233);
      n13 <= q1223;
      n22 <= q1133;
      n23 <= sneg(q1123);
      n33 <= ssub(q1122, q1212);
      s4_11 <= s3[0]; s4_33 <= s3[4]; s4_1212 <= q1212;
      s4c <= s3;
    end
  end

  // stage 5: det partial products
  logic signed [W-1:0] d1, d2;
  cgti_fmul #(W, FRAC_BITS) u_d0 (clk, en, s4_11, a11, d1);
  cgti_fmul #(W, FRAC_BITS) u_d1 (clk, en, s4_1212, s4_33, d2);
  logic signed [W-1:0] s5 [11];
  always_ff @(posedge clk) begin
    if (en) begin
      s5[0] <= s4c[0]; s5[1] <= s4c[1]; s5[2] <= s4c[2]; s5[3] <= s4c[3];
      s5[4] <= s4c[4]; s5[5] <= a11; s5[6] <= n12; s5[7] <= n13;
      s5[8] <= n22; s5[9] <= n23; s5[10] <= n33;
    end
  end

  // stage 6..9: determinant then delay to output register
  logic signed [W-1:0] det6;
  logic signed [W-1:0] s6 [11];
  always_ff @(posedge clk) begin
    if (en) begin
      det6 <= ssub(d1, d2);
      s6 <= s5;
    end
  end

  // packed: last, det, spare word, six numerators, five C terms, three spare words
  logic [16*W:0] pk6;
  always_comb begin
    pk6 = {lst[5], det6, W'(0), s6[10], s6[9], s6[8], s6[7], s6[6], s6[5],
           s6[4], s6[3], s6[2], s6[1], s6[0], (3*W)'(0)};
  end

  logic [16*W:0] pk7, pk8;
  always_ff @(posedge clk) begin
    if (en) begin
      pk7 <= pk6;
      pk8 <= pk7;
      out_data <= pk8;
    end
  end

endmodule

@@ rtl/cgti_back.sv @@
// ----------------------------------------------------------------------------
// cgti_back
// Back end: six pipelined restoring dividers, one quotient bit a stage,
// with an output register. Zero determinant forces the max value.
// ----------------------------------------------------------------------------
module cgti_back import cgti_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [16*DATA_WIDTH:0] in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [11*DATA_WIDTH:0] out_data
);

  localparam int W  = DATA_WIDTH;
  localparam int QW = W + FRAC_BITS;       // one quotient bit per numerator bit
  localparam int NW = W + FRAC_BITS;       // numerator magnitude bits
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

  // load stage, divider stages and output register
  logic [QW+1:0] vld;
  logic          en;
  assign en        = !vld[QW+1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[QW+1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[QW:0], in_valid};
  end

  // per-stage state: remainder, numerator shift, quotient, sign per lane
  logic [W:0]    rem [QW+1][6];
  logic [NW-1:0] num [QW+1][6];
  logic [QW-1:0] quo [QW+1][6];
  logic          sg  [QW+1][6];
  logic [W-1:0]  dm  [QW+1];
  logic          dz  [QW+1];
  logic [5*W:0]  pass [QW+1];

  // stage 0 load
  logic [W-1:0] det;
  assign det = in_data[16*W-1 -: W];
  always_ff @(posedge clk) begin
    if (en) begin
      dm[0] <= det[W-1] ? W'(-det) : det;
      dz[0] <= (det == '0);
      pass[0] <= {in_data[16*W], in_data[8*W-1:3*W]};
      for (int k = 0; k < 6; k++) begin
        logic [W-1:0] n;
        n = in_data[(8+k)*W +: W];
        num[0][k] <= {(n[W-1] ? W'(-n) : n), {FRAC_BITS{1'b0}}};
        sg[0][k]  <= n[W-1] ^ det[W-1];
        rem[0][k] <= '0;
        quo[0][k] <= '0;
      end
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < QW; s++) begin : g_st
    always_ff @(posedge clk) begin
      if (en) begin
        dm[s+1] <= dm[s]; dz[s+1] <= dz[s]; pass[s+1] <= pass[s];
        for (int k = 0; k < 6; k++) begin
          logic [W+1:0] r;
          logic [W+1:0] t;
          r = {rem[s][k], num[s][k][NW-1]};
          t = r - (W+2)'(dm[s]);
          sg[s+1][k]  <= sg[s][k];
          num[s+1][k] <= num[s][k] << 1;
          if (!t[W+1]) begin
            rem[s+1][k] <= t[W:0];
            quo[s+1][k] <= {quo[s][k][QW-2:0], 1'b1};
          end else begin
            rem[s+1][k] <= r[W:0];
            quo[s+1][k] <= {quo[s][k][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // saturate, sign, pack
  logic [11*W:0] res;
  always_comb begin
    res = '0;
    res[5*W-1:0] = pass[QW][5*W-1:0];
    res[11*W]    = pass[QW][5*W];
    for (int k = 0; k < 6; k++) begin
      logic [W-1:0] v;
      logic [QW-1:0] q;
      q = quo[QW][k];
      if (dz[QW]) v = VMAX;
      else if (!sg[QW][k]) v = (q > QW'(VMAX)) ? VMAX : q[W-1:0];
      else v = (q > QW'(VMAX) + QW'(1)) ? ~VMAX : W'(-q[W-1:0]);
      res[(5+k)*W +: W] = v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data <= res;
  end

endmodule

@@ rtl/cauchy_green_tensor_inverse_unit.sv @@
// ----------------------------------------------------------------------------
// cauchy_green_tensor_inverse_unit
// Right Cauchy-Green tensor C = F^T F and its inverse, signed fixed point.
// ----------------------------------------------------------------------------
// One request enters per cycle and one result leaves per cycle unless a
// stage stalls. Path: front pipeline (nine multiply/add stages), queue,
// divider pipeline (DATA_WIDTH+FRAC_BITS+2 stages: load, one per quotient
// bit, output register). Both pipelines stall as a whole when their output
// is not taken; the queue lets the front keep accepting while it has room.
module cauchy_green_tensor_inverse_unit import cgti_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // grad_11, grad_12, grad_22, grad_23, grad_33
  input  logic [5*DATA_WIDTH-1:0]  s_tdata,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // cg_11, cg_12, cg_22, cg_23, cg_33, inv_11, inv_12, inv_13, inv_22, inv_23, inv_33
  output logic [11*DATA_WIDTH-1:0] m_tdata,
  output logic                   m_tlast
);

  localparam int W  = DATA_WIDTH;
  localparam int QA = $clog2(QUEUE_DEPTH);

  logic          fv, fr;
  logic [16*W:0] fd;

  cgti_front #(W, FRAC_BITS) u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .f11(s_tdata[0 +: W]), .f12(s_tdata[W +: W]), .f22(s_tdata[2*W +: W]),
    .f23(s_tdata[3*W +: W]), .f33(s_tdata[4*W +: W]), .last_in(s_tlast),
    .out_valid(fv), .out_ready(fr), .out_data(fd)
  );

  // short queue between front and back
  logic [16*W:0] q [QUEUE_DEPTH];
  logic [QA-1:0] wp, rp;
  logic [QA:0]   cnt;
  logic          bv, br;
  assign fr = (cnt != (QA+1)'(QUEUE_DEPTH));
  assign bv = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (fv && fr) wp <= wp + 1'b1;
      if (bv && br) rp <= rp + 1'b1;
      cnt <= cnt + (QA+1)'(fv && fr) - (QA+1)'(bv && br);
    end
  end
  always_ff @(posedge clk) begin
    if (fv && fr) q[wp] <= fd;
  end

  logic [11*W:0] bd;
  cgti_back #(W, FRAC_BITS) u_back (
    .clk(clk), .rst(rst), .in_valid(bv), .in_ready(br), .in_data(q[rp]),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(bd)
  );

  assign m_tdata = bd[11*W-1:0];
  assign m_tlast = bd[11*W];

endmodule

@@ dv/cauchy_green_tensor_inverse_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cauchy-Green tensor and inverse unit testbench
// Drives deformation-gradient requests through the stream interface and
// checks each result, predicted bit-exact in fixed point or typed in, under
// several idling phases, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module cauchy_green_tensor_inverse_unit_test;
  import cgti_pkg::*;

  localparam int DW = DEF_DATA_WIDTH;
  localparam int FB = DEF_FRAC_BITS;
  localparam int NRAND = 1130;
  localparam int LATENCY = 9 + DW + FB + 2 + QUEUE_DEPTH + 8;

  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE  = 1 <<< FB;

  typedef logic signed [DW-1:0] fx_t;

  typedef struct packed {
    logic        last;
    fx_t [10:0]  val;  // index 0 = cg_11 ... 10 = inv_33
  } tensor_t;

  typedef struct {
    fx_t  g[5];
    logic last;
    logic known;   // expected result typed in
    fx_t  want[11];
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [5*DW-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [11*DW-1:0] m_tdata;
  logic m_tlast;

  tensor_t expected_tensors[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  event hold_go;
  logic hold_on = 1'b0;

  always #5 clk = ~clk;

  cauchy_green_tensor_inverse_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // Fixed-point arithmetic, saturating to DW bits
  function automatic fx_t sat_wide(logic signed [255:0] v);
    if (v > $signed({{(256-DW){1'b0}}, VMAX})) return VMAX;
    if (v < $signed({{(256-DW){1'b1}}, VMIN})) return VMIN;
    return v[DW-1:0];
  endfunction

  function automatic fx_t q_mul(fx_t a, fx_t b);
    logic signed [255:0] p;
    logic [255:0] m;
    p = $signed(a) * $signed(b);
    m = p < 0 ? -p : p;
    m = (m + (256'd1 << (FB - 1))) >> FB;  // round half away from zero
    return sat_wide(p < 0 ? -$signed(m) : $signed(m));
  endfunction

  function automatic fx_t q_add(fx_t a, fx_t b);
    logic signed [255:0] s;
    s = $signed(a) + $signed(b);
    return sat_wide(s);
  endfunction

  function automatic fx_t q_sub(fx_t a, fx_t b);
    logic signed [255:0] s;
    s = $signed(a) - $signed(b);
    return sat_wide(s);
  endfunction

  function automatic fx_t q_neg(fx_t a);
    return a == VMIN ? VMAX : -a;
  endfunction

  function automatic fx_t q_div(fx_t n, fx_t d);
    logic signed [255:0] nn, q;
    nn = $signed(n);
    nn = nn <<< FB;
    q = nn / $signed(d);  // truncates toward zero
    return sat_wide(q);
  endfunction

  // Predicted tensor and inverse for one grid point
  function automatic tensor_t predict_tensor(fx_t g[5], logic last);
    tensor_t t;
    fx_t c11, c12, c22, c23, c33, a11, det;
    c11 = q_mul(g[0], g[0]);
    c12 = q_mul(g[0], g[1]);
    c22 = q_add(q_add(q_mul(g[1], g[1]), q_mul(g[2], g[2])), q_mul(g[3], g[3]));
    c23 = q_mul(g[4], g[3]);
    c33 = q_mul(g[4], g[4]);
    a11 = q_sub(q_mul(c22, c33), q_mul(c23, c23));
    det = q_sub(q_mul(c11, a11), q_mul(q_mul(c12, c12), c33));
    t.last = last;
    t.val[0] = c11; t.val[1] = c12; t.val[2] = c22; t.val[3] = c23; t.val[4] = c33;
    if (det == 0) begin
      for (int i = 5; i < 11; i++) t.val[i] = VMAX;
    end else begin
      t.val[5]  = q_div(a11, det);
      t.val[6]  = q_div(q_neg(q_mul(c12, c33)), det);
      t.val[7]  = q_div(q_mul(c12, c23), det);
      t.val[8]  = q_div(q_mul(c11, c33), det);
      t.val[9]  = q_div(q_neg(q_mul(c11, c23)), det);
      t.val[10] = q_div(q_sub(q_mul(c11, c22), q_mul(c12, c12)), det);
    end
    return t;
  endfunction

  task automatic report_mismatch(string what, int idx, logic [DW-1:0] got,
                                 logic [DW-1:0] want);
    errors++;
    $display("MISMATCH %s[%0d]: got %h want %h at %0t", what, idx, got, want, $realtime);
  endtask

  // Send one request, then wait for its acceptance
  task automatic send_point(fx_t g[5], logic last, tensor_t exp_t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {g[4], g[3], g[2], g[1], g[0]};
    s_tlast  <= last;
    expected_tensors.push_back(exp_t);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_tensors.size() != 0) @(posedge clk);
  endtask

  function automatic fx_t rand_grad();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? VMIN : VMAX;
      2: return fx_t'($signed($urandom_range(0, 8 * ONE)) - 4 * ONE);
      default: return fx_t'($signed($urandom_range(0, 2 * ONE)) - ONE / 4 * 0 + ONE / 2);
    endcase
  endfunction

  // Long receiver hold-off, counted in cycles
  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (300) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Receiver: random stall, optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_on) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    tensor_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_tensors.size() == 0) begin
        report_mismatch("unexpected", 0, m_tdata[DW-1:0], '0);
      end else begin
        w = expected_tensors.pop_front();
        for (int i = 0; i < 11; i++)
          if (m_tdata[i*DW +: DW] !== w.val[i])
            report_mismatch("field", i, m_tdata[i*DW +: DW], w.val[i]);
        if (m_tlast !== w.last) report_mismatch("last", 0, DW'(m_tlast), DW'(w.last));
      end
    end
  end

  // Directed table and random phases
  initial begin
    row_t rows[$];
    row_t r;
    fx_t g[5];
    tensor_t t;
    logic lp;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity: C = I, inv = I
    r.g = '{ONE, 0, ONE, 0, ONE}; r.last = 1'b0; r.known = 1'b1;
    r.want = '{ONE, 0, ONE, 0, ONE, ONE, 0, 0, ONE, 0, ONE};
    rows.push_back(r);
    // all zero: zero determinant saturates the inverse
    r.g = '{0, 0, 0, 0, 0}; r.last = 1'b1;
    r.want = '{0, 0, 0, 0, 0, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX};
    rows.push_back(r);
    // zero F11 only: singular
    r.g = '{0, ONE, ONE, ONE, ONE}; r.last = 1'b0; r.known = 1'b0;
    rows.push_back(r);
    r.known = 1'b0;
    r.g = '{VMAX, VMAX, VMAX, VMAX, VMAX}; rows.push_back(r);
    r.g = '{VMIN, VMIN, VMIN, VMIN, VMIN}; r.last = 1'b1; rows.push_back(r);
    r.g = '{VMIN, VMAX, VMIN, VMAX, VMIN}; rows.push_back(r);
    r.g = '{2 * ONE, ONE, 3 * ONE, -ONE, ONE / 2}; r.last = 1'b0; rows.push_back(r);
    r.g = '{-ONE, ONE / 4, ONE, ONE / 8, -2 * ONE}; rows.push_back(r);
    r.g = '{1, -1, 1, -1, 1}; rows.push_back(r);           // products round to zero
    r.g = '{32'h0000_8000, 0, 32'h0000_8000, 0, 32'h0000_8000}; rows.push_back(r);
    r.g = '{ONE / 256, 0, ONE / 256, 0, ONE / 256}; rows.push_back(r);  // tiny values, det rounds to zero
    r.g = '{181 * ONE, 181 * ONE, 181 * ONE, 181 * ONE, 181 * ONE}; rows.push_back(r);
    r.g = '{ONE, 0, VMAX, 0, ONE}; r.last = 1'b1; rows.push_back(r);

    foreach (rows[k]) begin
      t = predict_tensor(rows[k].g, rows[k].last);
      if (rows[k].known)
        for (int i = 0; i < 11; i++) t.val[i] = rows[k].want[i];
      send_point(rows[k].g, rows[k].last, t);
    end
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 67 : (ph == 3) ? 30 : 0;
      recv_stall_pct = (ph == 2) ? 67 : (ph == 3) ? 30 : 0;
      for (int n = 0; n < NRAND / 4; n++) begin
        if (ph == 0 && n == 40) -> hold_go;  // back up the pipeline
        for (int i = 0; i < 5; i++) g[i] = rand_grad();
        lp = 1'($urandom_range(1));
        send_point(g, lp, predict_tensor(g, lp));
      end
      drain();
    end

    repeat (LATENCY) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
